// File: hw/rtl/prrs_pkg.sv
package prrs_pkg;

   // Table geometry. The index fields on the ports are fixed at ten bits.
   localparam int NUM_TASKS   = 1024;
   localparam int TASK_IDX_W  = $clog2(NUM_TASKS);
   localparam int FIELD_IDX_W = 10;
   localparam int STATUS_W    = 3;
   localparam int PRIO_W      = 8;
   localparam int ENTRY_W     = STATUS_W + PRIO_W;

   localparam logic [PRIO_W-1:0] IDLE_BOUND_RESET = PRIO_W'(100);

   // Entry status codes. Codes five to seven are stored but mean nothing.
   localparam logic [STATUS_W-1:0] STATUS_FREE         = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DYING        = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_RUNNABLE     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_RUNNING      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_RUNNABLE = 3'd4;

   // Item function codes.
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_SCHED = 1'b1;

   typedef enum logic [2:0] {
      DEC_WRITE = 3'd0,
      DEC_RUN   = 3'd1,
      DEC_KEEP  = 3'd2,
      DEC_HALT  = 3'd3,
      DEC_NONE  = 3'd4
   } decision_type;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_SCAN,
      FSM_DRAIN,
      FSM_FINISH
   } fsm_type;

endpackage

// File: hw/rtl/priority_round_robin_scheduler.sv
// Priority round-robin scheduler. The task table (status and priority of every entry) lives
// in one synchronous memory of NUM_TASKS entries. After reset the block first runs a clearing
// pass that writes every entry to free with priority zero, one entry per cycle, and takes no
// request beat until the pass is done; writes to the idle_bound register are taken at any
// time. A write beat stores one entry and answers with decision zero. A schedule beat reads
// the whole table once through the single read port, one entry per cycle, starting at the
// current task (or entry zero), and its answer is registered after the last entry has been
// read; the block works on one request beat at a time. Apart from the clearing pass the block
// only reports its decision and never changes the table on its own: software marks the
// chosen task as running through write beats.
module priority_round_robin_scheduler (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [9:0]  req_entry_index,
   input  logic [2:0]  req_entry_status,
   input  logic [7:0]  req_entry_priority,
   input  logic        req_has_current,
   input  logic [9:0]  req_current_index,
   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_decision,
   output logic [9:0]  rsp_chosen_index,
   // Configuration channel: the idle_bound register.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int IW = prrs_pkg::TASK_IDX_W;
   localparam int PW = prrs_pkg::PRIO_W;
   localparam int SW = prrs_pkg::STATUS_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(prrs_pkg::NUM_TASKS - 1);

   // Task table: priority in the low bits, status above it.
   logic [prrs_pkg::ENTRY_W-1:0] table_mem [prrs_pkg::NUM_TASKS];
   logic [prrs_pkg::ENTRY_W-1:0] rd_data_ff;

   prrs_pkg::fsm_type state_ff, state_in;

   logic [PW-1:0] idle_bound_ff;

   // Scan control.
   logic [IW-1:0] addr_ff, addr_in;
   logic [IW-1:0] count_ff, count_in;
   logic          rd_valid_ff, rd_first_ff;
   logic [IW-1:0] rd_addr_ff;

   // Scan results.
   logic          has_cur_ff;
   logic [IW-1:0] cur_ff;
   logic [PW-1:0] bound_ff;
   logic          have_best_ff, have_tie_ff;
   logic [IW-1:0] best_ff, tie_ff;
   logic          cur_running_ff;
   logic          live_ff;

   // Output register.
   logic                   rsp_valid_ff;
   prrs_pkg::decision_type rsp_decision_ff;
   logic [IW-1:0]          rsp_index_ff;

   // Control decoded from the state.
   logic          out_free;
   logic          req_take;
   logic          take_write;
   logic          take_sched;
   logic          scan_read;
   logic          load_result;
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   logic [prrs_pkg::ENTRY_W-1:0] mem_wdata;
   logic          write_in_range;

   prrs_pkg::decision_type fin_decision;
   logic [IW-1:0]          fin_index;

   logic [SW-1:0] rd_status;
   logic [PW-1:0] rd_prio;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // A write beat needs the output register at once; a schedule beat only at its end. Both
   // are held off together so that stall never depends on the payload.
   assign req_stall  = (state_ff != prrs_pkg::FSM_IDLE) || !out_free;
   assign req_take   = req_valid && !req_stall;
   assign take_write = req_take && (req_func == prrs_pkg::FUNC_WRITE);
   assign take_sched = req_take && (req_func == prrs_pkg::FUNC_SCHED);

   assign write_in_range = 32'(req_entry_index) < prrs_pkg::NUM_TASKS;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prrs_pkg::FSM_CLEAR: begin
            if (addr_ff == LAST_IDX) state_in = prrs_pkg::FSM_IDLE;
         end
         prrs_pkg::FSM_IDLE: begin
            if (take_sched) state_in = prrs_pkg::FSM_SCAN;
         end
         prrs_pkg::FSM_SCAN: begin
            if (count_ff == LAST_IDX) state_in = prrs_pkg::FSM_DRAIN;
         end
         prrs_pkg::FSM_DRAIN: begin
            state_in = prrs_pkg::FSM_FINISH;
         end
         prrs_pkg::FSM_FINISH: begin
            if (out_free) state_in = prrs_pkg::FSM_IDLE;
         end
         default: state_in = prrs_pkg::FSM_CLEAR;
      endcase
   end

   // Outputs of the state machine: memory port control and result loading.
   always_comb begin
      mem_we      = 1'b0;
      mem_waddr   = addr_ff;
      mem_wdata   = '0;
      scan_read   = 1'b0;
      load_result = 1'b0;
      case (state_ff)
         prrs_pkg::FSM_CLEAR: begin
            mem_we = 1'b1;
         end
         prrs_pkg::FSM_IDLE: begin
            mem_we    = take_write && write_in_range;
            mem_waddr = IW'(req_entry_index);
            mem_wdata = {req_entry_status, req_entry_priority};
         end
         prrs_pkg::FSM_SCAN: begin
            scan_read = 1'b1;
         end
         prrs_pkg::FSM_DRAIN: begin
         end
         prrs_pkg::FSM_FINISH: begin
            load_result = out_free;
         end
         default: begin
         end
      endcase
   end

   // Address and entry counter: the clearing pass and the circular scan share the address.
   always_comb begin
      addr_in  = addr_ff;
      count_in = count_ff;
      if (state_ff == prrs_pkg::FSM_CLEAR) begin
         addr_in = (addr_ff == LAST_IDX) ? '0 : addr_ff + 1'b1;
      end else if (take_sched) begin
         addr_in  = req_has_current ? IW'(req_current_index) : '0;
         count_in = '0;
      end else if (scan_read) begin
         addr_in  = (addr_ff == LAST_IDX) ? '0 : addr_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= prrs_pkg::FSM_CLEAR;
         addr_ff       <= '0;
         count_ff      <= '0;
         idle_bound_ff <= prrs_pkg::IDLE_BOUND_RESET;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         addr_ff     <= addr_in;
         count_ff    <= count_in;
         rd_valid_ff <= scan_read;
         if (csr_valid && csr_ready) idle_bound_ff <= csr_data;
         if (take_write || load_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // The table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) table_mem[mem_waddr] <= mem_wdata;
      if (scan_read) rd_data_ff <= table_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (scan_read) begin
         rd_first_ff <= (count_ff == '0);
         rd_addr_ff  <= addr_ff;
      end
   end

   assign rd_status = rd_data_ff[prrs_pkg::ENTRY_W-1:PW];
   assign rd_prio   = rd_data_ff[PW-1:0];

   // Scan datapath. With a current task the first entry read is that task itself: it sets
   // the bound and tells whether the task is running, but it is no candidate. Every entry
   // read counts towards the liveness check that decides between halt and no live task.
   always_ff @(posedge clock) begin
      if (take_sched) begin
         has_cur_ff     <= req_has_current;
         cur_ff         <= IW'(req_current_index);
         bound_ff       <= idle_bound_ff;
         have_best_ff   <= 1'b0;
         have_tie_ff    <= 1'b0;
         best_ff        <= '0;
         tie_ff         <= '0;
         cur_running_ff <= 1'b0;
         live_ff        <= 1'b0;
      end else if (rd_valid_ff) begin
         if (rd_status == prrs_pkg::STATUS_RUNNABLE || rd_status == prrs_pkg::STATUS_RUNNING
             || rd_status == prrs_pkg::STATUS_DYING) begin
            live_ff <= 1'b1;
         end
         if (rd_first_ff && has_cur_ff) begin
            bound_ff       <= rd_prio;
            cur_running_ff <= (rd_status == prrs_pkg::STATUS_RUNNING);
         end else if (rd_status == prrs_pkg::STATUS_RUNNABLE) begin
            if (rd_prio < bound_ff) begin
               bound_ff     <= rd_prio;
               best_ff      <= rd_addr_ff;
               have_best_ff <= 1'b1;
               have_tie_ff  <= 1'b0;
            end else if (!have_tie_ff && rd_prio == bound_ff) begin
               tie_ff      <= rd_addr_ff;
               have_tie_ff <= 1'b1;
            end
         end
      end
   end

   // Final decision, in order of precedence: a more urgent task, an equally urgent one,
   // keeping a running current task, then halt or no live task.
   always_comb begin
      fin_decision = prrs_pkg::DEC_NONE;
      fin_index    = '0;
      if (have_best_ff) begin
         fin_decision = prrs_pkg::DEC_RUN;
         fin_index    = best_ff;
      end else if (have_tie_ff) begin
         fin_decision = prrs_pkg::DEC_RUN;
         fin_index    = tie_ff;
      end else if (has_cur_ff && cur_running_ff) begin
         fin_decision = prrs_pkg::DEC_KEEP;
         fin_index    = cur_ff;
      end else if (live_ff) begin
         fin_decision = prrs_pkg::DEC_HALT;
      end
   end

   always_ff @(posedge clock) begin
      if (take_write) begin
         rsp_decision_ff <= prrs_pkg::DEC_WRITE;
         rsp_index_ff    <= '0;
      end else if (load_result) begin
         rsp_decision_ff <= fin_decision;
         rsp_index_ff    <= fin_index;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_decision     = rsp_decision_ff;
   assign rsp_chosen_index = prrs_pkg::FIELD_IDX_W'(rsp_index_ff);

endmodule
